[sv/icfp_pkg.sv]
// icfp_pkg: shared types, constants, the crc helper and the frame id helper of the imu can frame packer
// used by every module of the block, depends on nothing

package icfp_pkg;

	localparam int GAIN_W  = 18;
	localparam int LEVEL_W = 16;
	localparam int RAW_W   = 16;
	localparam int SMP_W   = RAW_W + 1;
	localparam int CFG_W   = 18;
	localparam int IDX_W   = 2;
	localparam int ID_W    = 11;
	localparam int CNT_W   = 4;

	localparam int NUM_LANES    = 3;
	localparam int LANE_W       = $clog2(NUM_LANES);
	localparam int SCALE_STAGES = 3;
	localparam int N_STAGES     = SCALE_STAGES + 4;

	localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(NUM_LANES - 1);

	localparam logic [7:0] CRC_POLY = 8'h1D;
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_XOR  = 8'hFF;

	localparam logic [ID_W-1:0] ID_YAW   = 11'h174;
	localparam logic [ID_W-1:0] ID_ROLL  = 11'h178;
	localparam logic [ID_W-1:0] ID_PITCH = 11'h17C;

	localparam logic [GAIN_W-1:0]  ACCEL_GAIN_RST     = 18'd62720;
	localparam logic [GAIN_W-1:0]  GYRO_GAIN_RST      = 18'd100000;
	localparam logic [LEVEL_W-1:0] CENTER_OFFSET_RST  = 16'd32768;
	localparam logic [LEVEL_W-1:0] OUTPUT_CEILING_RST = 16'd65534;

	typedef enum logic [IDX_W-1:0] {
		REG_ACCEL_GAIN,
		REG_GYRO_GAIN,
		REG_CENTER_OFFSET,
		REG_OUTPUT_CEILING
	} reg_idx_t;

	typedef struct packed {
		logic signed [RAW_W-1:0] accel_x;
		logic signed [RAW_W-1:0] accel_y;
		logic signed [RAW_W-1:0] accel_z;
		logic signed [RAW_W-1:0] gyro_x;
		logic signed [RAW_W-1:0] gyro_y;
		logic signed [RAW_W-1:0] gyro_z;
	} sample_t;

	typedef struct packed {
		logic [ID_W-1:0]    frame_id;
		logic [LEVEL_W-1:0] rate_value;
		logic [7:0]         status_byte;
		logic [7:0]         spare_byte;
		logic [LEVEL_W-1:0] accel_value;
		logic [7:0]         count_byte;
		logic [7:0]         crc_value;
		logic               last_frame;
	} frame_t;

	// what one lane hands to the merge stage
	typedef struct packed {
		logic [LEVEL_W-1:0] rate;
		logic [LEVEL_W-1:0] accel;
		logic [CNT_W-1:0]   count;
		logic [7:0]         crc;
	} lane_res_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [ID_W-1:0] frame_id_of(input logic [LANE_W-1:0] lane);
		logic [ID_W-1:0] id;
		unique case (lane)
			2'd0:    id = ID_YAW;
			2'd1:    id = ID_ROLL;
			default: id = ID_PITCH;
		endcase
		return id;
	endfunction

endpackage

[sv/icfp_scale.sv]
// icfp_scale: floor(sample * gain / 65535) + offset, clamped to 0..ceiling, three stages
// depends on icfp_pkg

module icfp_scale import icfp_pkg::*; (
	input  logic                      clk,
	input  logic [SCALE_STAGES-1:0]   en,
	input  logic signed [SMP_W-1:0]   sample,
	input  logic [GAIN_W-1:0]         gain,
	input  logic [LEVEL_W-1:0]        offset,
	input  logic [LEVEL_W-1:0]        ceiling,
	output logic [LEVEL_W-1:0]        value
);

	logic signed [34:0] prod_full;
	logic signed [34:0] prod_s1;
	logic [18:0]        a_s2;
	logic [19:0]        s_s2;
	logic [LEVEL_W-1:0] value_s3;

	logic [3:0]  c;
	logic [17:0] t;
	logic [19:0] corr;
	logic [19:0] q;
	logic [20:0] v;
	logic [LEVEL_W-1:0] clamped;

	assign prod_full = 35'(sample) * 35'($signed({1'b0, gain}));

	// x = 65536a + b = 65535a + (a + b), so floor(x/65535) = a + floor((a+b)/65535);
	// the same split once more leaves a correction of -1, 0 or +1
	always_comb begin
		c    = s_s2[19:16];
		t    = {{14{c[3]}}, c} + {2'b00, s_s2[15:0]};
		if (t[17])
			corr = '1;
		else if (t >= 18'd65535)
			corr = 20'd1;
		else
			corr = '0;
		q = {a_s2[18], a_s2} + {{16{c[3]}}, c} + corr;
		v = {q[19], q} + {5'b0, offset};
		if (v[20])
			clamped = '0;
		else if (v[19:0] > {4'b0, ceiling})
			clamped = ceiling;
		else
			clamped = v[15:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= prod_full;
		end
		if (en[1]) begin
			a_s2 <= prod_s1[34:16];
			s_s2 <= {prod_s1[34], prod_s1[34:16]} + {4'b0, prod_s1[15:0]};
		end
		if (en[2]) begin
			value_s3 <= clamped;
		end
	end

	assign value = value_s3;

endmodule

[sv/icfp_lane.sv]
// icfp_lane: one frame's worth of work, rate and accel scaling then the frame crc
// depends on icfp_pkg and icfp_scale

module icfp_lane import icfp_pkg::*; (
	input  logic                     clk,
	input  logic [N_STAGES-1:0]      stage_en,
	input  logic signed [SMP_W-1:0]  rate_sample,
	input  logic signed [SMP_W-1:0]  accel_sample,
	input  logic [GAIN_W-1:0]        accel_gain,
	input  logic [GAIN_W-1:0]        gyro_gain,
	input  logic [LEVEL_W-1:0]       center_offset,
	input  logic [LEVEL_W-1:0]       output_ceiling,
	input  logic [CNT_W-1:0]         count,
	output lane_res_t                result
);

	logic [LEVEL_W-1:0] rate_val;
	logic [LEVEL_W-1:0] accel_val;
	logic [CNT_W-1:0]   cnt_s1, cnt_s2, cnt_s3, cnt_s4, cnt_s5, cnt_s6;
	logic [LEVEL_W-1:0] rate_s4, rate_s5, rate_s6, rate_s7;
	logic [LEVEL_W-1:0] accel_s4, accel_s5, accel_s6, accel_s7;
	logic [7:0]         crc_s4, crc_s5, crc_s6, crc_s7;
	logic [CNT_W-1:0]   cnt_s7;

	icfp_scale u_rate (
		.clk     (clk),
		.en      (stage_en[SCALE_STAGES-1:0]),
		.sample  (rate_sample),
		.gain    (gyro_gain),
		.offset  (center_offset),
		.ceiling (output_ceiling),
		.value   (rate_val)
	);

	icfp_scale u_accel (
		.clk     (clk),
		.en      (stage_en[SCALE_STAGES-1:0]),
		.sample  (accel_sample),
		.gain    (accel_gain),
		.offset  (center_offset),
		.ceiling (output_ceiling),
		.value   (accel_val)
	);

	// crc runs two payload bytes per stage, the count byte alone in the last one
	always_ff @(posedge clk) begin
		if (stage_en[0]) cnt_s1 <= count;
		if (stage_en[1]) cnt_s2 <= cnt_s1;
		if (stage_en[2]) cnt_s3 <= cnt_s2;
		if (stage_en[3]) begin
			cnt_s4   <= cnt_s3;
			rate_s4  <= rate_val;
			accel_s4 <= accel_val;
			crc_s4   <= crc8_byte(crc8_byte(CRC_INIT, rate_val[7:0]), rate_val[15:8]);
		end
		if (stage_en[4]) begin
			cnt_s5   <= cnt_s4;
			rate_s5  <= rate_s4;
			accel_s5 <= accel_s4;
			crc_s5   <= crc8_byte(crc8_byte(crc_s4, 8'h00), 8'h00);
		end
		if (stage_en[5]) begin
			cnt_s6   <= cnt_s5;
			rate_s6  <= rate_s5;
			accel_s6 <= accel_s5;
			crc_s6   <= crc8_byte(crc8_byte(crc_s5, accel_s5[7:0]), accel_s5[15:8]);
		end
		if (stage_en[6]) begin
			cnt_s7   <= cnt_s6;
			rate_s7  <= rate_s6;
			accel_s7 <= accel_s6;
			crc_s7   <= crc8_byte(crc_s6, {4'b0, cnt_s6}) ^ CRC_XOR;
		end
	end

	assign result = '{rate: rate_s7, accel: accel_s7, count: cnt_s7, crc: crc_s7};

endmodule

[sv/icfp_merge.sv]
// icfp_merge: holds the three lane results of one sample and sends them as frames
// depends on icfp_pkg

module icfp_merge import icfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tail_valid,
	input  lane_res_t lanes [NUM_LANES],
	output logic      load_ok,
	output logic      frame_valid,
	input  logic      frame_ready,
	output frame_t    frame
);

	lane_res_t         buf_q [NUM_LANES];
	logic              full_q;
	logic [LANE_W-1:0] idx_q;
	logic              take;
	logic              beat;
	lane_res_t         cur;

	assign beat    = full_q && frame_ready;
	// a new sample may come in as the last frame of the previous one leaves
	assign load_ok = !full_q || (frame_ready && idx_q == LAST_LANE);
	assign take    = tail_valid && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			full_q <= 1'b1;
			idx_q  <= '0;
		end else if (beat) begin
			if (idx_q == LAST_LANE)
				full_q <= 1'b0;
			else
				idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) buf_q <= lanes;
	end

	assign cur         = buf_q[idx_q];
	assign frame_valid = full_q;

	always_comb begin
		frame.frame_id    = frame_id_of(idx_q);
		frame.rate_value  = cur.rate;
		frame.status_byte = 8'h00;
		frame.spare_byte  = 8'h00;
		frame.accel_value = cur.accel;
		frame.count_byte  = {4'b0, cur.count};
		frame.crc_value   = cur.crc;
		frame.last_frame  = (idx_q == LAST_LANE);
	end

endmodule

[sv/imu_can_frame_packer_unit.sv]
// imu_can_frame_packer_unit: top level, config registers, rolling count, lane pipeline control
// depends on icfp_pkg, icfp_lane (with icfp_scale) and icfp_merge
//
// usage:
//   sample channel (sample_valid/sample_ready/sample) takes one six-axis raw sample a beat.
//   frame channel (frame_valid/frame_ready/frame) gives three frames per sample, in the
//   order 0x174 (yaw, accel y), 0x178 (negated roll, accel x), 0x17C (pitch, accel z).
//   the write port (wr_en/wr_index/wr_data) sets gains, offset and ceiling; write only
//   while no sample is in flight.
//   three lanes, one per frame, run a 7 stage pipeline: multiply, two stages of
//   division by 65535 with offset and clamp, then four crc stages, two bytes a stage
//   and the count byte alone in the last.
//   the first frame is valid once the sample has passed the pipeline into the merge buffer.
//   the sample rate is set by the single frame channel, which sends one frame a cycle while
//   frame_ready is high; the merge stage takes the next sample as the last frame leaves.
//   reset clears the pipeline, the merge buffer and the rolling count, and loads the
//   register defaults; sample_ready is already high while reset is held.
//   when frame_ready is low the merge buffer holds, the pipeline fills behind it and
//   sample_ready drops once every stage is occupied.

module imu_can_frame_packer_unit import icfp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  sample_t          sample,
	output logic             frame_valid,
	input  logic             frame_ready,
	output frame_t           frame,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data
);

	logic [GAIN_W-1:0]  accel_gain_q;
	logic [GAIN_W-1:0]  gyro_gain_q;
	logic [LEVEL_W-1:0] center_offset_q;
	logic [LEVEL_W-1:0] output_ceiling_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [N_STAGES-1:0] valid_q;
	logic [N_STAGES-1:0] free;
	logic               load_ok;
	logic               in_beat;

	logic signed [SMP_W-1:0] rate_smp  [NUM_LANES];
	logic signed [SMP_W-1:0] accel_smp [NUM_LANES];
	lane_res_t               lane_res  [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_gain_q     <= ACCEL_GAIN_RST;
			gyro_gain_q      <= GYRO_GAIN_RST;
			center_offset_q  <= CENTER_OFFSET_RST;
			output_ceiling_q <= OUTPUT_CEILING_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_ACCEL_GAIN:     accel_gain_q     <= wr_data[GAIN_W-1:0];
				REG_GYRO_GAIN:      gyro_gain_q      <= wr_data[GAIN_W-1:0];
				REG_CENTER_OFFSET:  center_offset_q  <= wr_data[LEVEL_W-1:0];
				REG_OUTPUT_CEILING: output_ceiling_q <= wr_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage can load when it is empty or its content moves on
	always_comb begin
		free[N_STAGES-1] = !valid_q[N_STAGES-1] || load_ok;
		for (int k = N_STAGES - 2; k >= 0; k--) begin
			free[k] = !valid_q[k] || free[k+1];
		end
	end

	assign sample_ready = free[0];
	assign in_beat      = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else begin
			valid_q <= (free & {valid_q[N_STAGES-2:0], sample_valid}) | (~free & valid_q);
			if (in_beat) cnt_q <= cnt_q + 1'b1;
		end
	end

	assign rate_smp[0]  = {sample.gyro_z[RAW_W-1], sample.gyro_z};
	assign rate_smp[1]  = -{sample.gyro_x[RAW_W-1], sample.gyro_x};
	assign rate_smp[2]  = {sample.gyro_y[RAW_W-1], sample.gyro_y};
	assign accel_smp[0] = {sample.accel_y[RAW_W-1], sample.accel_y};
	assign accel_smp[1] = {sample.accel_x[RAW_W-1], sample.accel_x};
	assign accel_smp[2] = {sample.accel_z[RAW_W-1], sample.accel_z};

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		icfp_lane u_lane (
			.clk            (clk),
			.stage_en       (free),
			.rate_sample    (rate_smp[g]),
			.accel_sample   (accel_smp[g]),
			.accel_gain     (accel_gain_q),
			.gyro_gain      (gyro_gain_q),
			.center_offset  (center_offset_q),
			.output_ceiling (output_ceiling_q),
			.count          (cnt_q),
			.result         (lane_res[g])
		);
	end

	icfp_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.tail_valid  (valid_q[N_STAGES-1]),
		.lanes       (lane_res),
		.load_ok     (load_ok),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> cnt_q == $past(cnt_q) + 4'd1)
		else $error("rolling count did not step on a sample beat");

	a_last_is_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame.last_frame |-> frame.frame_id == ID_PITCH)
		else $error("last frame of a sample is not the pitch frame");

	a_count_shared: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_ready && !frame.last_frame |=>
			frame_valid && $stable(frame.count_byte))
		else $error("frames of one sample carry different counts");

	a_tail_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[N_STAGES-1] && !load_ok |=> valid_q[N_STAGES-1])
		else $error("held pipeline tail lost its sample");

endmodule
